>>> src/assert_macros.svh
// assertion macros for the checker file
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every clock edge outside reset
`define PBI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// implication: pre at this edge, post at the next
`define PBI_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle property failed");

`endif

>>> src/pbi_pkg.sv
// shared constants, types and helpers of the beamformer power integrator
// no dependencies
package pbi_pkg;

    localparam int MAX_ANTENNAS    = 16;
    localparam int MAX_BEAMS       = 16;
    localparam int MAX_INTEGRATION = 1024;

    localparam int ANT_W    = 6;
    localparam int BEAM_W   = 6;
    localparam int CFG_W    = 7;
    localparam int SPO_W    = 11;
    localparam int SAMP_W   = 8;
    localparam int PH_W     = 16;
    localparam int SUM_W    = 32;
    localparam int POWER_W  = 48;
    localparam int SQSUM_W  = 34;
    localparam int CIDX_W   = 2;

    localparam int TAB_DEPTH = MAX_BEAMS * MAX_ANTENNAS;
    localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam int BEAM_AW   = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam int CNT_W     = $clog2(MAX_INTEGRATION + 1);

    localparam logic [CIDX_W-1:0] CFG_ANTENNAS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BEAMS    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SPO      = 2'd2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_CAP
    } state_t;

    // one beam update launched into the pipeline
    typedef struct packed {
        logic               valid;
        logic [BEAM_AW-1:0] beam;
        logic               ant0;
        logic               last_ant;
        logic               sum_ok;
    } issue_t;

    // clamp a register value into 1..hi
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_W'(1);
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

>>> src/pbi_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module pbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/pbi_beam_pipe.sv
// per-beam read-modify-write pipeline: complex mac, detection, integration
// depends on pbi_pkg
module pbi_beam_pipe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pbi_pkg::issue_t               issue,
    input  logic signed [pbi_pkg::SAMP_W-1:0] sre,
    input  logic signed [pbi_pkg::SAMP_W-1:0] sim,
    input  logic [2*pbi_pkg::PH_W-1:0]    phasor_rdata,
    input  logic [2*pbi_pkg::SUM_W-1:0]   sum_rdata,
    output logic                          sum_we,
    output logic [pbi_pkg::BEAM_AW-1:0]   sum_waddr,
    output logic [2*pbi_pkg::SUM_W-1:0]   sum_wdata,
    output logic                          integ_re,
    output logic [pbi_pkg::BEAM_AW-1:0]   integ_raddr,
    input  logic                          integ_ok,
    input  logic [pbi_pkg::POWER_W-1:0]   integ_rdata,
    output logic                          integ_we,
    output logic [pbi_pkg::BEAM_AW-1:0]   integ_waddr,
    output logic [pbi_pkg::POWER_W-1:0]   integ_wdata,
    output logic                          busy
);
    import pbi_pkg::*;

    issue_t s1_reg, s2_reg, s3_reg, s4_reg;
    logic signed [24:0] pr_reg, pi_reg;
    logic [SUM_W-1:0]   old_re_reg, old_im_reg;
    logic [SUM_W-1:0]   sum_re_reg, sum_im_reg;
    logic [SQSUM_W-1:0] det_reg;
    logic               ok_reg;

    logic signed [PH_W-1:0]  pre, pim;
    logic signed [23:0]      m_rr, m_ii, m_ri, m_ir;
    logic signed [24:0]      pr, pi;
    logic signed [16:0]      q_re, q_im;
    logic signed [33:0]      sq_re, sq_im;
    logic [POWER_W:0]        acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else
        begin
            s1_reg <= issue;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
        end
    end

    // stage 1: complex product
    always_comb
    begin
        pre  = phasor_rdata[PH_W-1:0];
        pim  = phasor_rdata[2*PH_W-1:PH_W];
        m_rr = sre * pre;
        m_ii = sim * pim;
        m_ri = sre * pim;
        m_ir = sim * pre;
        pr   = {m_rr[23], m_rr} - {m_ii[23], m_ii};
        pi   = {m_ri[23], m_ri} + {m_ir[23], m_ir};
    end

    always_ff @(posedge clk)
    begin
        pr_reg <= pr;
        pi_reg <= pi;
        // antenna 0 or a never written sum starts from zero
        if (s1_reg.ant0 || !s1_reg.sum_ok)
        begin
            old_re_reg <= '0;
            old_im_reg <= '0;
        end
        else
        begin
            old_re_reg <= sum_rdata[SUM_W-1:0];
            old_im_reg <= sum_rdata[2*SUM_W-1:SUM_W];
        end
        // stage 2: wrapping accumulate
        sum_re_reg <= old_re_reg + {{(SUM_W-25){pr_reg[24]}}, pr_reg};
        sum_im_reg <= old_im_reg + {{(SUM_W-25){pi_reg[24]}}, pi_reg};
        // stage 3: floor shift and square
        det_reg <= SQSUM_W'(sq_re) + SQSUM_W'(sq_im);
        ok_reg  <= integ_ok;
    end

    always_comb
    begin
        q_re  = sum_re_reg[SUM_W-1:15];
        q_im  = sum_im_reg[SUM_W-1:15];
        sq_re = q_re * q_re;
        sq_im = q_im * q_im;
    end

    assign sum_we      = s3_reg.valid;
    assign sum_waddr   = s3_reg.beam;
    assign sum_wdata   = {sum_im_reg, sum_re_reg};
    assign integ_re    = s3_reg.valid && s3_reg.last_ant;
    assign integ_raddr = s3_reg.beam;

    // stage 4: saturating integration
    always_comb
    begin
        acc = (ok_reg ? {1'b0, integ_rdata} : '0) + (POWER_W+1)'(det_reg);
    end

    assign integ_we    = s4_reg.valid && s4_reg.last_ant;
    assign integ_waddr = s4_reg.beam;
    assign integ_wdata = acc[POWER_W] ? {POWER_W{1'b1}} : acc[POWER_W-1:0];

    assign busy = s1_reg.valid || s2_reg.valid || s3_reg.valid || s4_reg.valid;

endmodule

>>> src/phased_beamformer_power_integrator.sv
// top level of the phased beamformer with power integration
// depends on pbi_pkg, pbi_ram, pbi_beam_pipe
//
// Fan beamformer with detected power integration. Load words (mode 0)
// store one Q1.15 complex phasor per beam and antenna. Sample words
// (mode 1) carry one int8 complex voltage; each beam's complex sum is read
// from ram, updated with sample times phasor and written back, one beam
// per cycle, so a sample word occupies the block for the beam sweep plus
// the draining of the update pipeline. Samples at or beyond
// antennas_in_use are taken and dropped. After the last antenna the same
// pipeline floors each sum by 2^15, squares it and adds into the beam
// integrator (saturating at 48 bits). When samples_per_output time samples
// are done, one power word per beam goes out, each read from its
// integrator and then captured into the output register, and the
// integrators restart from zero. Phasors must be loaded before use.
// Sum and integrator rams carry per-entry valid flops, so no clearing pass
// is needed after reset. The config port is always ready; write it only
// while the block is idle.
module phased_beamformer_power_integrator (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbi_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [pbi_pkg::SPO_W-1:0]       cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [pbi_pkg::ANT_W-1:0]       antenna,
    input  logic [pbi_pkg::BEAM_W-1:0]      beam_select,
    input  logic signed [pbi_pkg::SAMP_W-1:0] sample_re,
    input  logic signed [pbi_pkg::SAMP_W-1:0] sample_im,
    input  logic signed [pbi_pkg::PH_W-1:0] phasor_re,
    input  logic signed [pbi_pkg::PH_W-1:0] phasor_im,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pbi_pkg::BEAM_W-1:0]      beam_index,
    output logic [pbi_pkg::POWER_W-1:0]     power,
    output logic                            last
);
    import pbi_pkg::*;

    // config registers
    logic [CFG_W-1:0] antennas_reg;
    logic [CFG_W-1:0] beams_reg;
    logic [SPO_W-1:0] spo_reg;

    // control
    state_t             state_reg, state_next;
    logic [BEAM_AW-1:0] beam_cnt_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [ANT_W-1:0]   ant_reg;
    logic               ant0_reg, last_ant_reg;
    logic signed [SAMP_W-1:0] sre_reg, sim_reg;
    logic [MAX_BEAMS-1:0] sum_vld_reg;
    logic [MAX_BEAMS-1:0] integ_vld_reg;
    logic                 emit_ok_reg;

    // output word register
    logic               out_valid_reg;
    logic [BEAM_W-1:0]  beam_index_reg;
    logic [POWER_W-1:0] power_reg;
    logic               last_reg;

    logic [CFG_W-1:0] nant, nbeam;
    int unsigned      nint;
    logic             in_take, sample_go, beam_last, out_free, period_hit;
    logic             sweep_issue, emit_read, emit_cap;
    issue_t           issue;

    // ram wiring
    logic                 ph_we;
    logic [TAB_AW-1:0]    ph_waddr, ph_raddr;
    logic [2*PH_W-1:0]    ph_rdata;
    logic                 sum_we;
    logic [BEAM_AW-1:0]   sum_waddr;
    logic [2*SUM_W-1:0]   sum_wdata, sum_rdata;
    logic                 pipe_integ_re, integ_re, integ_we, integ_ok, busy;
    logic [BEAM_AW-1:0]   pipe_integ_raddr, integ_raddr, integ_waddr;
    logic [POWER_W-1:0]   integ_wdata, integ_rdata;

    // effective counts after clamping
    always_comb
    begin
        nant  = clamp_cfg(antennas_reg, CFG_W'(MAX_ANTENNAS));
        nbeam = clamp_cfg(beams_reg, CFG_W'(MAX_BEAMS));
        if (spo_reg == '0) nint = 1;
        else if (32'(spo_reg) > MAX_INTEGRATION) nint = MAX_INTEGRATION;
        else nint = 32'(spo_reg);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            antennas_reg <= CFG_W'(16);
            beams_reg    <= CFG_W'(16);
            spo_reg      <= SPO_W'(64);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ANTENNAS: antennas_reg <= cfg_data[CFG_W-1:0];
                CFG_BEAMS:    beams_reg    <= cfg_data[CFG_W-1:0];
                CFG_SPO:      spo_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign in_take   = in_valid && !in_stall;
    assign sample_go = in_take && (mode == MODE_SAMPLE) && ({1'b0, antenna} < nant);
    assign beam_last = ({{(CFG_W-BEAM_AW){1'b0}}, beam_cnt_reg} == nbeam - CFG_W'(1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign period_hit = (32'(count_reg) + 1) >= nint;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_go) state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (beam_last) state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    if (last_ant_reg && period_hit) state_next = ST_EMIT_RD;
                    else state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_CAP;
            end
            ST_EMIT_CAP:
            begin
                if (out_free)
                begin
                    if (beam_last) state_next = ST_IDLE;
                    else state_next = ST_EMIT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall    = 1'b1;
        sweep_issue = 1'b0;
        emit_read   = 1'b0;
        emit_cap    = 1'b0;
        case (state_reg)
            ST_IDLE:     in_stall    = 1'b0;
            ST_SWEEP:    sweep_issue = 1'b1;
            ST_DRAIN:    ;
            ST_EMIT_RD:  emit_read   = 1'b1;
            ST_EMIT_CAP: emit_cap    = out_free;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            beam_cnt_reg  <= '0;
            count_reg     <= '0;
            sum_vld_reg   <= '0;
            integ_vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sample_go)
            begin
                beam_cnt_reg <= '0;
            end
            else if (sweep_issue && !beam_last)
            begin
                beam_cnt_reg <= beam_cnt_reg + BEAM_AW'(1);
            end
            else if (sweep_issue)
            begin
                beam_cnt_reg <= '0;
            end
            else if (emit_cap)
            begin
                beam_cnt_reg <= beam_last ? '0 : beam_cnt_reg + BEAM_AW'(1);
            end
            // time sample bookkeeping once the pipeline is empty
            if (state_reg == ST_DRAIN && !busy && last_ant_reg)
            begin
                count_reg <= period_hit ? '0 : count_reg + CNT_W'(1);
            end
            if (sum_we)
            begin
                sum_vld_reg[sum_waddr] <= 1'b1;
            end
            if (integ_we)
            begin
                integ_vld_reg[integ_waddr] <= 1'b1;
            end
            // all integrators restart after the final beam goes out
            if (emit_cap && beam_last)
            begin
                integ_vld_reg <= '0;
            end
            if (emit_cap)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // held sample and payload registers
    always_ff @(posedge clk)
    begin
        if (sample_go)
        begin
            ant_reg      <= antenna;
            ant0_reg     <= (antenna == '0);
            last_ant_reg <= ({1'b0, antenna} == nant - CFG_W'(1));
            sre_reg      <= sample_re;
            sim_reg      <= sample_im;
        end
        if (emit_read)
        begin
            emit_ok_reg <= integ_vld_reg[beam_cnt_reg];
        end
        if (emit_cap)
        begin
            beam_index_reg <= BEAM_W'(beam_cnt_reg);
            power_reg      <= emit_ok_reg ? integ_rdata : '0;
            last_reg       <= beam_last;
        end
    end

    // phasor table: loads write, the sweep reads
    assign ph_we    = in_take && (mode == MODE_LOAD) && (32'(antenna) < MAX_ANTENNAS)
                      && (32'(beam_select) < MAX_BEAMS);
    assign ph_waddr = TAB_AW'(32'(beam_select) * MAX_ANTENNAS + 32'(antenna));
    assign ph_raddr = TAB_AW'(32'(beam_cnt_reg) * MAX_ANTENNAS + 32'(ant_reg));

    always_comb
    begin
        issue.valid    = sweep_issue;
        issue.beam     = beam_cnt_reg;
        issue.ant0     = ant0_reg;
        issue.last_ant = last_ant_reg;
        issue.sum_ok   = sum_vld_reg[beam_cnt_reg];
    end

    // integrator read port is shared by the pipeline and the emit sweep
    assign integ_re    = pipe_integ_re || emit_read;
    assign integ_raddr = emit_read ? beam_cnt_reg : pipe_integ_raddr;
    assign integ_ok    = integ_vld_reg[pipe_integ_raddr];

    pbi_ram #(.WIDTH(2*PH_W), .DEPTH(TAB_DEPTH)) u_phasor_ram (
        .clk   (clk),
        .we    (ph_we),
        .waddr (ph_waddr),
        .wdata ({phasor_im, phasor_re}),
        .re    (sweep_issue),
        .raddr (ph_raddr),
        .rdata (ph_rdata)
    );

    pbi_ram #(.WIDTH(2*SUM_W), .DEPTH(MAX_BEAMS)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sweep_issue),
        .raddr (beam_cnt_reg),
        .rdata (sum_rdata)
    );

    pbi_ram #(.WIDTH(POWER_W), .DEPTH(MAX_BEAMS)) u_integ_ram (
        .clk   (clk),
        .we    (integ_we),
        .waddr (integ_waddr),
        .wdata (integ_wdata),
        .re    (integ_re),
        .raddr (integ_raddr),
        .rdata (integ_rdata)
    );

    pbi_beam_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .sre          (sre_reg),
        .sim          (sim_reg),
        .phasor_rdata (ph_rdata),
        .sum_rdata    (sum_rdata),
        .sum_we       (sum_we),
        .sum_waddr    (sum_waddr),
        .sum_wdata    (sum_wdata),
        .integ_re     (pipe_integ_re),
        .integ_raddr  (pipe_integ_raddr),
        .integ_ok     (integ_ok),
        .integ_rdata  (integ_rdata),
        .integ_we     (integ_we),
        .integ_waddr  (integ_waddr),
        .integ_wdata  (integ_wdata),
        .busy         (busy)
    );

    assign out_valid  = out_valid_reg;
    assign beam_index = beam_index_reg;
    assign power      = power_reg;
    assign last       = last_reg;

endmodule

>>> src/pbi_checker.sv
// port-level checks of the beamformer power integrator, bound to the top
// depends on assert_macros.svh
`include "assert_macros.svh"

module pbi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_ready,
    input logic       in_valid,
    input logic       in_stall,
    input logic       mode,
    input logic [5:0] antenna,
    input logic       out_valid,
    input logic       out_stall,
    input logic [5:0] beam_index
);

    // a stalled result word stays put
    `PBI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `PBI_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(beam_index))
    // config port never pushes back
    `PBI_ASSERT(a_cfg_ready, cfg_ready)
    // antenna 0 is always in use, so its word starts a beam sweep
    `PBI_ASSERT_NEXT(a_sweep_start, in_valid && !in_stall && mode && antenna == 6'd0, in_stall)

endmodule

bind phased_beamformer_power_integrator pbi_checker u_pbi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ready  (cfg_ready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .antenna    (antenna),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .beam_index (beam_index)
);

>>> dv/tb.sv
// self-checking testbench for phased_beamformer_power_integrator
// depends on pbi_pkg and the rtl of the block; needs no other files
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbi_pkg::*;

    localparam longint POWER_MAX = 64'hFFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 64;
    // the phasor fill covers beams below FILL_SPAN on every antenna and
    // antennas below FILL_SPAN on every beam
    localparam int FILL_SPAN = 4;

    // one input word as driven on the payload ports
    typedef struct {
        logic        md;
        logic [5:0]  ant;
        logic [5:0]  bsel;
        logic [7:0]  sre;
        logic [7:0]  sim;
        logic [15:0] pre;
        logic [15:0] pim;
        longint      typed_power; // expected power of beam 0 read off by hand, -1 if none
    } stim_row_t;

    // one expected power word
    typedef struct {
        logic [5:0]  beam;
        logic [47:0] power;
        logic        last;
    } power_word_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [SPO_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic mode;
    logic [ANT_W-1:0] antenna;
    logic [BEAM_W-1:0] beam_select;
    logic signed [SAMP_W-1:0] sample_re;
    logic signed [SAMP_W-1:0] sample_im;
    logic signed [PH_W-1:0] phasor_re;
    logic signed [PH_W-1:0] phasor_im;
    logic out_valid;
    logic out_stall;
    logic [BEAM_W-1:0] beam_index;
    logic [POWER_W-1:0] power;
    logic last;

    // receiver stall is the per-word draw or the long hold-off
    logic draw_stall;
    logic hold_stall;
    assign out_stall = draw_stall | hold_stall;

    phased_beamformer_power_integrator uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .antenna(antenna),
        .beam_select(beam_select),
        .sample_re(sample_re),
        .sample_im(sample_im),
        .phasor_re(phasor_re),
        .phasor_im(phasor_im),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .beam_index(beam_index),
        .power(power),
        .last(last)
    );

    // ---------------------------------------------------------------
    // beamformer predictor state: registers, phasors, sums, integrators
    // ---------------------------------------------------------------
    logic [6:0]  reg_antennas;
    logic [6:0]  reg_beams;
    logic [10:0] reg_spo;
    logic signed [15:0] tab_re [MAX_BEAMS][MAX_ANTENNAS];
    logic signed [15:0] tab_im [MAX_BEAMS][MAX_ANTENNAS];
    logic signed [31:0] sum_re [MAX_BEAMS];
    logic signed [31:0] sum_im [MAX_BEAMS];
    longint integ [MAX_BEAMS];
    int time_count;

    power_word_t power_q[$];
    int errors;
    bit calm;          // no idling on either side while set
    longint typed_power;
    bit typed_armed;

    function automatic int clamp_count(int v, int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // write one register into the predictor copy
    function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [SPO_W-1:0] val);
        case (idx)
            CFG_ANTENNAS: reg_antennas = val[6:0];
            CFG_BEAMS:    reg_beams = val[6:0];
            CFG_SPO:      reg_spo = val;
            default:      ;
        endcase
    endfunction

    // one accepted input word: update state and queue any power words
    function automatic void integrate_word(logic md, logic [5:0] ant, logic [5:0] bsel,
                                           logic signed [7:0] sre, logic signed [7:0] sim,
                                           logic signed [15:0] pre, logic signed [15:0] pim);
        int nant;
        int nbeam;
        int nint;
        longint pr;
        longint pi;
        longint qr;
        longint qi;
        longint acc;
        logic signed [31:0] fr;
        logic signed [31:0] fi;
        power_word_t w;
        nant = clamp_count(reg_antennas, MAX_ANTENNAS);
        nbeam = clamp_count(reg_beams, MAX_BEAMS);
        nint = clamp_count(reg_spo, MAX_INTEGRATION);
        if (md == MODE_LOAD) begin
            // out-of-range loads are dropped
            if (ant < MAX_ANTENNAS && bsel < MAX_BEAMS) begin
                tab_re[bsel][ant] = pre;
                tab_im[bsel][ant] = pim;
            end
            return;
        end
        if (ant >= nant)
            return;
        for (int b = 0; b < nbeam; b++) begin
            pr = longint'(sre) * longint'(tab_re[b][ant]) - longint'(sim) * longint'(tab_im[b][ant]);
            pi = longint'(sre) * longint'(tab_im[b][ant]) + longint'(sim) * longint'(tab_re[b][ant]);
            if (ant == 0) begin
                sum_re[b] = '0;
                sum_im[b] = '0;
            end
            sum_re[b] = sum_re[b] + pr[31:0];
            sum_im[b] = sum_im[b] + pi[31:0];
        end
        if (ant + 1 != nant)
            return;
        for (int b = 0; b < nbeam; b++) begin
            fr = sum_re[b] >>> 15;
            fi = sum_im[b] >>> 15;
            qr = longint'(fr);
            qi = longint'(fi);
            acc = integ[b] + qr * qr + qi * qi;
            integ[b] = (acc > POWER_MAX) ? POWER_MAX : acc;
        end
        time_count++;
        if (time_count >= nint) begin
            for (int b = 0; b < nbeam; b++) begin
                w.beam = b[5:0];
                w.power = integ[b][47:0];
                w.last = (b + 1 == nbeam);
                power_q.push_back(w);
            end
            // hand-read value of a directed row
            if (typed_armed && integ[0] != typed_power) begin
                errors++;
                if (errors <= 10)
                    $display("directed power mismatch: expected %0d got %0d",
                             typed_power, integ[0]);
            end
            typed_armed = 0;
            for (int b = 0; b < MAX_BEAMS; b++)
                integ[b] = 0;
            time_count = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // monitors: config writes, accepted input words, output words
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                integrate_word(mode, antenna, beam_select, sample_re, sample_im,
                               phasor_re, phasor_im);
            if (out_valid && !out_stall) begin
                if (power_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected power word: beam %0d power %0d last %0b",
                                 beam_index, power, last);
                end
                else begin
                    power_word_t w;
                    w = power_q.pop_front();
                    if (w.beam !== beam_index || w.power !== power || w.last !== last) begin
                        errors++;
                        if (errors <= 10)
                            $display("power mismatch: expected beam %0d power %0d last %0b, got beam %0d power %0d last %0b",
                                     w.beam, w.power, w.last, beam_index, power, last);
                    end
                end
            end
        end
    end

    // clock
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #3ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stall before every word, none while calm
    initial begin
        int n;
        draw_stall = 0;
        @(posedge rst_n);
        forever begin
            n = calm ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (n > 0) begin
                draw_stall = 1;
                repeat (n) @(negedge clk);
            end
            draw_stall = 0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    // long receiver hold-off so the block backs up into its input
    task automatic hold_receiver(int cycles);
        @(negedge clk);
        hold_stall = 1;
        repeat (cycles) @(negedge clk);
        hold_stall = 0;
    endtask

    // sender: random gap, then hold the word until accepted
    task automatic send_word(stim_row_t r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        mode = r.md;
        antenna = r.ant;
        beam_select = r.bsel;
        sample_re = r.sre;
        sample_im = r.sim;
        phasor_re = r.pre;
        phasor_im = r.pim;
        if (r.typed_power >= 0) begin
            typed_power = r.typed_power;
            typed_armed = 1;
        end
        in_valid = 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = val[SPO_W-1:0];
        cfg_valid = 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // drain everything expected, then give the pipeline time to go quiet
    task automatic settle();
        @(negedge clk);
        in_valid = 0;
        wait (power_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic stim_row_t random_word(bit md, int ant, int bsel);
        stim_row_t r;
        r.md = md;
        r.ant = ant[5:0];
        r.bsel = bsel[5:0];
        r.sre = 8'($urandom);
        r.sim = 8'($urandom);
        r.pre = 16'($urandom);
        r.pim = 16'($urandom);
        r.typed_power = -1;
        return r;
    endfunction

    // one setting of the registers followed by random traffic
    task automatic run_phase(int ants, int beams, int spo, int words, bit quiet, bit squeeze);
        int nant;
        int sent;
        int pick;
        write_reg(CFG_ANTENNAS, ants);
        write_reg(CFG_BEAMS, beams);
        write_reg(CFG_SPO, spo);
        nant = clamp_count(ants & 7'h7F, MAX_ANTENNAS);
        calm = quiet;
        if (squeeze)
            fork
                hold_receiver(300);
            join_none
        sent = 0;
        while (sent < words) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // noise: any antenna, any mode, any beam
                send_word(random_word(1'($urandom_range(0, 1)), $urandom_range(0, 63),
                                      $urandom_range(0, 63)));
                sent++;
            end
            else if (pick == 1) begin
                send_word(random_word(MODE_LOAD, $urandom_range(0, MAX_ANTENNAS - 1),
                                      $urandom_range(0, MAX_BEAMS - 1)));
                sent++;
            end
            else begin
                // one well-formed time sample
                for (int a = 0; a < nant; a++)
                    send_word(random_word(MODE_SAMPLE, a, $urandom_range(0, 63)));
                sent += nant;
            end
        end
        settle();
        calm = 0;
    endtask

    // directed rows: phasors of beams 0 and 1, then samples and special cases
    // (antennas 2, beams 2, one time sample per result)
    stim_row_t directed [16] = '{
        '{MODE_LOAD,   6'd0,  6'd0,  8'h00, 8'h00, 16'h7FFF, 16'h0000, -1},
        '{MODE_LOAD,   6'd1,  6'd0,  8'h00, 8'h00, 16'h8000, 16'h8000, -1},
        '{MODE_LOAD,   6'd0,  6'd1,  8'h00, 8'h00, 16'h0000, 16'h7FFF, -1},
        '{MODE_LOAD,   6'd1,  6'd1,  8'h00, 8'h00, 16'h8000, 16'h7FFF, -1},
        // loads beyond the table are dropped
        '{MODE_LOAD,   6'd63, 6'd63, 8'hFF, 8'hFF, 16'h0001, 16'h0001, -1},
        '{MODE_LOAD,   6'd16, 6'd0,  8'h00, 8'h00, 16'hFFFF, 16'hFFFF, -1},
        '{MODE_LOAD,   6'd0,  6'd16, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, -1},
        // most negative sample times full-scale phasor floors to -128 per part
        '{MODE_SAMPLE, 6'd0,  6'd63, 8'h80, 8'h80, 16'h0000, 16'h0000, -1},
        '{MODE_SAMPLE, 6'd1,  6'd0,  8'h00, 8'h00, 16'h0000, 16'h0000, 32768},
        // antenna beyond those in use is ignored
        '{MODE_SAMPLE, 6'd5,  6'd0,  8'h7F, 8'h7F, 16'h0000, 16'h0000, -1},
        // last antenna without antenna 0 keeps adding to the old sums
        '{MODE_SAMPLE, 6'd1,  6'd0,  8'h7F, 8'h80, 16'h0000, 16'h0000, -1},
        // repeated antenna 0 restarts the sums each time
        '{MODE_SAMPLE, 6'd0,  6'd0,  8'h7F, 8'h7F, 16'h0000, 16'h0000, -1},
        '{MODE_SAMPLE, 6'd0,  6'd0,  8'hFF, 8'hFF, 16'h0000, 16'h0000, -1},
        '{MODE_SAMPLE, 6'd1,  6'd0,  8'h80, 8'h7F, 16'h0000, 16'h0000, -1},
        // zero voltage gives zero power
        '{MODE_SAMPLE, 6'd0,  6'd0,  8'h00, 8'h00, 16'h0000, 16'h0000, -1},
        '{MODE_SAMPLE, 6'd1,  6'd0,  8'h00, 8'h00, 16'h0000, 16'h0000, 0}
    };

    // main sequence
    initial begin
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = CFG_ANTENNAS;
        cfg_data = '0;
        in_valid = 0;
        mode = MODE_LOAD;
        antenna = '0;
        beam_select = '0;
        sample_re = '0;
        sample_im = '0;
        phasor_re = '0;
        phasor_im = '0;
        hold_stall = 0;
        errors = 0;
        calm = 0;
        typed_armed = 0;
        typed_power = 0;
        reg_antennas = 7'd16;
        reg_beams = 7'd16;
        reg_spo = 11'd64;
        time_count = 0;
        for (int b = 0; b < MAX_BEAMS; b++) begin
            sum_re[b] = '0;
            sum_im[b] = '0;
            integ[b] = 0;
            for (int a = 0; a < MAX_ANTENNAS; a++) begin
                tab_re[b][a] = '0;
                tab_im[b][a] = '0;
            end
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed part on a small array
        write_reg(CFG_ANTENNAS, 2);
        write_reg(CFG_BEAMS, 2);
        write_reg(CFG_SPO, 1);
        foreach (directed[i])
            send_word(directed[i]);
        settle();

        // fill the phasor entries that the random phases read: the first
        // beams on every antenna and the first antennas on every beam
        for (int b = 0; b < MAX_BEAMS; b++)
            for (int a = 0; a < MAX_ANTENNAS; a++)
                if (b < FILL_SPAN || a < FILL_SPAN)
                    send_word(random_word(MODE_LOAD, a, b));
        settle();

        // random phases, extremes included; wide antenna settings keep to the
        // first beams and wide beam settings to the first antennas; the 2047
        // phase leaves a part period that the following one-sample setting
        // cuts short
        run_phase(4, 5, 3, 16, 0, 0);
        run_phase(1, 16, 1, 10, 1, 0);
        run_phase(4, 16, 1, 16, 1, 1);
        run_phase(127, 4, 2047, 16, 0, 0);
        run_phase(2, 3, 1, 8, 0, 0);
        run_phase(0, 0, 0, 6, 0, 0);
        run_phase(4, 127, 2, 10, 0, 0);
        run_phase(16, 1, 2, 16, 0, 0);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
